// ===== rtl/fly_camera_orientation_update_unit_assert.svh =====
// Assertion macros for the camera orientation update unit.
// Included by the modules that check their own control logic.
`ifndef FLY_CAMERA_ORIENTATION_UPDATE_UNIT_ASSERT_SVH
`define FLY_CAMERA_ORIENTATION_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define FCO_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FCO_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define FCO_ASSERT_IMPL(label, clk, rst_n, a, c)
`define FCO_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/fco_pkg.sv =====
// Package for the camera orientation update unit: formats, constants, tables.
// No dependencies.
`timescale 1ns / 1ps
package fco_pkg;
    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_ROWS = 24;
    localparam int NITER = (TRIG_ITERATIONS > ATAN_ROWS) ? ATAN_ROWS : TRIG_ITERATIONS;
    localparam int IW = $clog2(NITER + 1);
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] DEG90 = 34'sd5898240;
    localparam logic signed [33:0] DEG180 = 34'sd11796480;
    localparam logic signed [33:0] DEG89 = 34'sd5832704;
    localparam logic signed [31:0] YAW_RESET = -32'sd5898240;

    typedef enum logic [2:0] {
        DIR_FORWARD = 3'd0, DIR_BACK = 3'd1, DIR_LEFT = 3'd2,
        DIR_RIGHT = 3'd3, DIR_DOWN = 3'd4, DIR_UP = 3'd5
    } dir_t;

    typedef enum logic [2:0] {
        CFG_SPEED = 3'd0, CFG_SENS = 3'd1, CFG_START_X = 3'd2,
        CFG_START_Y = 3'd3, CFG_START_Z = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } result_t;

    typedef struct packed {
        logic               start;
        logic signed [33:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } cordic_rsp_t;

    function automatic logic signed [33:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0: atan_deg = 34'sd2949120;  5'd1: atan_deg = 34'sd1740967;
            5'd2: atan_deg = 34'sd919879;   5'd3: atan_deg = 34'sd466945;
            5'd4: atan_deg = 34'sd234379;   5'd5: atan_deg = 34'sd117304;
            5'd6: atan_deg = 34'sd58666;    5'd7: atan_deg = 34'sd29335;
            5'd8: atan_deg = 34'sd14668;    5'd9: atan_deg = 34'sd7334;
            5'd10: atan_deg = 34'sd3667;    5'd11: atan_deg = 34'sd1833;
            5'd12: atan_deg = 34'sd917;     5'd13: atan_deg = 34'sd458;
            5'd14: atan_deg = 34'sd229;     5'd15: atan_deg = 34'sd115;
            5'd16: atan_deg = 34'sd57;      5'd17: atan_deg = 34'sd29;
            5'd18: atan_deg = 34'sd14;      5'd19: atan_deg = 34'sd7;
            5'd20: atan_deg = 34'sd4;       5'd21: atan_deg = 34'sd2;
            5'd22: atan_deg = 34'sd1;
            default: atan_deg = 34'sd0;
        endcase
    endfunction

    function automatic logic signed [15:0] clamp14(input logic signed [47:0] v);
        if (v > 48'sd16384) clamp14 = 16'sd16384;
        else if (v < -48'sd16384) clamp14 = -16'sd16384;
        else clamp14 = v[15:0];
    endfunction
endpackage

// ===== rtl/fco_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface fco_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fco_cordic.sv =====
// Iterative CORDIC sine/cosine in degrees, one rotation per cycle.
// Depends on fco_pkg.
`timescale 1ns / 1ps
module fco_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  fco_pkg::cordic_req_t req,
    output fco_pkg::cordic_rsp_t rsp
);
    import fco_pkg::*;
    `include "fly_camera_orientation_update_unit_assert.svh"

    logic signed [33:0] x_reg, y_reg, a_reg;
    logic               flip_reg, busy_reg, done_reg;
    logic [IW-1:0]      i_reg;
    logic signed [33:0] a_fold, xs, ys;
    logic               f_fold;

    always_comb
    begin
        a_fold = req.angle;
        f_fold = 1'b0;
        if (req.angle > DEG90) begin a_fold = req.angle - DEG180; f_fold = 1'b1; end
        else if (req.angle < -DEG90) begin a_fold = req.angle + DEG180; f_fold = 1'b1; end
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                a_reg    <= a_fold;
                flip_reg <= f_fold;
                i_reg    <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (i_reg == IW'(NITER))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (!a_reg[33])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        a_reg <= a_reg - atan_deg(5'(i_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        a_reg <= a_reg + atan_deg(5'(i_reg));
                    end
                    i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.cos_v = flip_reg ? -x_reg : x_reg;
    assign rsp.sin_v = flip_reg ? -y_reg : y_reg;

    `FCO_ASSERT_NEXT(a_done_ends, clk, rst_n, done_reg, !done_reg)
    `FCO_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `FCO_ASSERT_IMPL(a_iter_range, clk, rst_n, busy_reg, i_reg <= IW'(NITER))
endmodule

// ===== rtl/fco_serial_mul.sv =====
// Signed shift-add multiplier, one multiplier bit per cycle.
// Depends on fco_pkg.
`timescale 1ns / 1ps
module fco_serial_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic               done,
    output logic signed [67:0] p
);
    import fco_pkg::*;

    logic signed [67:0] acc_reg, mc_reg;
    logic [33:0]        mb_reg;
    logic [5:0]         n_reg;
    logic               busy_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                acc_reg  <= '0;
                mc_reg   <= 68'(a);
                mb_reg   <= b;
                n_reg    <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // top bit of b has negative weight
                if (mb_reg[0])
                    acc_reg <= (n_reg == 6'd33) ? acc_reg - mc_reg : acc_reg + mc_reg;
                mc_reg <= mc_reg <<< 1;
                mb_reg <= mb_reg >> 1;
                n_reg  <= n_reg + 1'b1;
                if (n_reg == 6'd33)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule

// ===== rtl/fly_camera_orientation_update_unit.sv =====
// Camera orientation update unit: sequencer, state, serial arithmetic.
// Depends on fco_pkg, fco_if, fco_cordic, fco_serial_mul.
`timescale 1ns / 1ps
// Usage:
//   in  : sink channel, beat = {kind, move_dir, delta_time, x_offset, y_offset}.
//   out : source channel, beat = result_t (position and front/right/up vectors).
//   cfg_we/cfg_idx/cfg_data: register writes, only while idle. A start_* write
//   also loads that position component at once.
// One item at a time. From accept to result valid, an item runs two CORDIC
// passes, up to six products on one bit-serial 34x34 multiplier, then the
// output register is loaded. A key move with an unused direction skips both
// step products; an up or down move has one. Most of each item's time goes
// to the serial multiplier.
// A new beat is taken when the previous result is handed over or while it
// waits in the output register, so the next item overlaps the stall.
// Reset: speed 5.0, sensitivity 0.2, position 0, yaw -90, pitch 0, no result.
// A stalled receiver holds the result register; the unit finishes its
// current item and then waits.
module fly_camera_orientation_update_unit (
    input  logic        clk,
    input  logic        rst_n,
    fco_if.sink         in_ch,
    fco_if.source       out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_data
);
    import fco_pkg::*;
    `include "fly_camera_orientation_update_unit_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_MOUSE, S_MUL_WAIT, S_TRIG_Y, S_TRIG_P, S_MUL, S_STEP, S_OUT
    } state_t;

    state_t             state_reg;
    logic [15:0]        speed_reg, sens_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] yaw_reg, pitch_reg;
    logic               kind_reg;
    logic [2:0]         dir_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] xo_reg, yo_reg;
    logic signed [33:0] cy_reg, sy_reg, cp_reg, sp_reg;
    logic signed [67:0] prod_reg [6];
    logic [3:0]         job_reg;
    logic               mstart_reg;
    logic signed [33:0] ma, mb;
    logic               mdone;
    logic signed [67:0] mp;
    cordic_req_t        creq;
    cordic_rsp_t        crsp;
    logic               cstart_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               take;

    assign take = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !cfg_we;

    assign creq.start = cstart_reg;
    assign creq.angle = (state_reg == S_TRIG_P) ? 34'(pitch_reg) : 34'(yaw_reg);

    fco_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));
    fco_serial_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart_reg), .a(ma), .b(mb),
                          .done(mdone), .p(mp));

    // Q1.14 horizontal trig terms
    logic signed [15:0] cy14, sy14, c0, c2;
    logic signed [33:0] vspeed;
    assign cy14 = clamp14(48'((cy_reg + 34'sd32768) >>> 16));
    assign sy14 = clamp14(48'((sy_reg + 34'sd32768) >>> 16));
    assign vspeed = 34'({16'd0, speed_reg} * {16'd0, dt_reg});

    always_comb
    begin
        c0 = 16'sd0;
        c2 = 16'sd0;
        unique case (dir_reg)
            DIR_FORWARD: begin c0 = cy14;  c2 = sy14;  end
            DIR_BACK:    begin c0 = -cy14; c2 = -sy14; end
            DIR_LEFT:    begin c0 = sy14;  c2 = -cy14; end
            DIR_RIGHT:   begin c0 = -sy14; c2 = cy14;  end
            DIR_DOWN:    begin c0 = -16'sd16384; end
            DIR_UP:      begin c0 = 16'sd16384;  end
            default:     ;
        endcase
    end

    // operand selection per multiplier job
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (job_reg)
            4'd0: begin ma = 34'(xo_reg); mb = 34'(sens_reg); end
            4'd1: begin ma = 34'(yo_reg); mb = 34'(sens_reg); end
            4'd2: begin ma = cy_reg; mb = cp_reg; end
            4'd3: begin ma = sy_reg; mb = cp_reg; end
            4'd4: begin ma = cy_reg; mb = sp_reg; end
            4'd5: begin ma = sy_reg; mb = sp_reg; end
            4'd6: begin ma = vspeed; mb = 34'(c0); end
            4'd7: begin ma = vspeed; mb = 34'(c2); end
            default: ;
        endcase
    end

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [67:0] d);
        logic signed [67:0] s;
        s = 68'(p) + d;
        if (s > 68'sd2147483647) sat_add = 32'sh7fffffff;
        else if (s < -68'sd2147483648) sat_add = 32'sh80000000;
        else sat_add = s[31:0];
    endfunction

    logic signed [67:0] dmouse, dstep;
    logic signed [33:0] yaw_n, pit_n;
    assign dmouse = (prod_reg[0] + 68'sd128) >>> 8;
    assign dstep  = (mp + 68'sd2097152) >>> 22;
    always_comb
    begin
        yaw_n = 34'(yaw_reg) + 34'(dmouse);
        if (yaw_n >= DEG180) yaw_n = yaw_n - 2 * DEG180;
        else if (yaw_n < -DEG180) yaw_n = yaw_n + 2 * DEG180;
        pit_n = 34'(pitch_reg) + 34'((mp + 68'sd128) >>> 8);
        if (pit_n > DEG89) pit_n = DEG89;
        if (pit_n < -DEG89) pit_n = -DEG89;
    end

    function automatic logic signed [15:0] r46(input logic signed [67:0] v);
        r46 = clamp14(48'((v + (68'sd1 <<< 45)) >>> 46));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            speed_reg     <= 16'd1280;
            sens_reg      <= 16'd13107;
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            pos_reg[2]    <= '0;
            yaw_reg       <= YAW_RESET;
            pitch_reg     <= '0;
            out_valid_reg <= 1'b0;
            mstart_reg    <= 1'b0;
            cstart_reg    <= 1'b0;
            job_reg       <= '0;
        end
        else
        begin
            mstart_reg <= 1'b0;
            cstart_reg <= 1'b0;
            // S_OUT reloads the result register itself
            if (out_ch.valid && out_ch.ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_SPEED:   speed_reg  <= cfg_data[15:0];
                    CFG_SENS:    sens_reg   <= cfg_data[15:0];
                    CFG_START_X: pos_reg[0] <= cfg_data;
                    CFG_START_Y: pos_reg[1] <= cfg_data;
                    CFG_START_Z: pos_reg[2] <= cfg_data;
                    default:     ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (take)
                    begin
                        kind_reg <= in_ch.data[51];
                        dir_reg  <= in_ch.data[50:48];
                        dt_reg   <= in_ch.data[47:32];
                        xo_reg   <= in_ch.data[31:16];
                        yo_reg   <= in_ch.data[15:0];
                        job_reg  <= '0;
                        if (in_ch.data[51])
                        begin
                            mstart_reg <= 1'b1;
                            state_reg  <= S_MOUSE;
                        end
                        else
                        begin
                            cstart_reg <= 1'b1;
                            state_reg  <= S_TRIG_Y;
                        end
                    end
                S_MOUSE:
                    if (mdone)
                    begin
                        prod_reg[0] <= mp;
                        job_reg     <= 4'd1;
                        mstart_reg  <= 1'b1;
                        state_reg   <= S_MUL_WAIT;
                    end
                S_MUL_WAIT:
                    if (mdone)
                    begin
                        yaw_reg    <= yaw_n[31:0];
                        pitch_reg  <= pit_n[31:0];
                        cstart_reg <= 1'b1;
                        state_reg  <= S_TRIG_Y;
                    end
                S_TRIG_Y:
                    if (crsp.done)
                    begin
                        cy_reg     <= crsp.cos_v;
                        sy_reg     <= crsp.sin_v;
                        cstart_reg <= 1'b1;
                        state_reg  <= S_TRIG_P;
                    end
                S_TRIG_P:
                    if (crsp.done)
                    begin
                        cp_reg     <= crsp.cos_v;
                        sp_reg     <= crsp.sin_v;
                        job_reg    <= 4'd2;
                        mstart_reg <= 1'b1;
                        state_reg  <= S_MUL;
                    end
                S_MUL:
                    if (mdone)
                    begin
                        prod_reg[3'(job_reg)] <= mp;
                        if (job_reg == 4'd5)
                        begin
                            if (!kind_reg && dir_reg <= DIR_UP)
                            begin
                                job_reg    <= 4'd6;
                                mstart_reg <= 1'b1;
                                state_reg  <= S_STEP;
                            end
                            else
                                state_reg <= S_OUT;
                        end
                        else
                        begin
                            job_reg    <= job_reg + 4'd1;
                            mstart_reg <= 1'b1;
                        end
                    end
                S_STEP:
                    if (mdone)
                    begin
                        if (dir_reg == DIR_DOWN || dir_reg == DIR_UP)
                        begin
                            pos_reg[1] <= sat_add(pos_reg[1], dstep);
                            state_reg  <= S_OUT;
                        end
                        else if (job_reg == 4'd6)
                        begin
                            pos_reg[0] <= sat_add(pos_reg[0], dstep);
                            job_reg    <= 4'd7;
                            mstart_reg <= 1'b1;
                        end
                        else
                        begin
                            pos_reg[2] <= sat_add(pos_reg[2], dstep);
                            state_reg  <= S_OUT;
                        end
                    end
                S_OUT:
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_reg.pos_x   <= pos_reg[0];
                        out_reg.pos_y   <= pos_reg[1];
                        out_reg.pos_z   <= pos_reg[2];
                        out_reg.front_x <= r46(prod_reg[2]);
                        out_reg.front_y <= clamp14(48'((sp_reg + 34'sd32768) >>> 16));
                        out_reg.front_z <= r46(prod_reg[3]);
                        out_reg.right_x <= -sy14;
                        out_reg.right_y <= 16'sd0;
                        out_reg.right_z <= cy14;
                        out_reg.up_x    <= -r46(prod_reg[4]);
                        out_reg.up_y    <= clamp14(48'((cp_reg + 34'sd32768) >>> 16));
                        out_reg.up_z    <= -r46(prod_reg[5]);
                        out_valid_reg   <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    `FCO_ASSERT_NEXT(a_take_leaves_idle, clk, rst_n, take, state_reg != S_IDLE)
    `FCO_ASSERT_IMPL(a_pitch_clamped, clk, rst_n, 1'b1,
        pitch_reg <= 32'(DEG89) && pitch_reg >= -32'(DEG89))
    `FCO_ASSERT_IMPL(a_right_y_zero, clk, rst_n, out_valid_reg, out_reg.right_y == 16'sd0)
endmodule

// ===== tb/fly_camera_orientation_update_unit_checker.sv =====
// Scoreboard for the camera orientation update unit: tracks register writes,
// predicts each result from accepted input beats and compares the output beats.
// Depends on fco_pkg and fco_if.
`timescale 1ns / 1ps
module fly_camera_orientation_update_unit_checker
    import fco_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fco_if              in_ch,
    fco_if              out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_data,
    output int          outstanding,
    output int          mismatches,
    output int          results_seen
);
    localparam longint ANG90  = 64'sd5898240;
    localparam longint ANG180 = 64'sd11796480;
    localparam longint ANG89  = 64'sd5832704;

    // camera state as the unit should hold it
    logic [15:0] speed_q8;
    logic [15:0] sens_q16;
    int          cam_pos [3];
    int          yaw_q16;
    int          pitch_q16;
    result_t     pending_results [$];

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic int sat_pos(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    // degree-domain CORDIC, Q2.30 results
    function automatic void trig(longint ang, output longint c, output longint s);
        longint x, y, nx;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (ang > ANG90) begin
            ang -= ANG180;
            flip = 1;
        end
        else if (ang < -ANG90) begin
            ang += ANG180;
            flip = 1;
        end
        for (int i = 0; i < NITER; i++) begin
            if (ang >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                ang -= longint'(atan_deg(5'(i)));
            end
            else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                ang += longint'(atan_deg(5'(i)));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void move_axis(int k, longint v, longint c);
        cam_pos[k] = sat_pos(longint'(cam_pos[k]) + rnd_shift(v * c, 22));
    endfunction

    function automatic result_t camera_update(logic [51:0] beat);
        logic          is_mouse;
        logic [2:0]    dir;
        longint        dt, xo, yo, yaw, pitch, cy, sy, cp, sp, cy14, sy14, v;
        result_t       r;
        is_mouse = beat[51];
        dir      = beat[50:48];
        dt       = longint'(beat[47:32]);
        xo       = longint'(signed'(beat[31:16]));
        yo       = longint'(signed'(beat[15:0]));
        if (is_mouse) begin
            yaw   = longint'(yaw_q16) + rnd_shift(xo * longint'(sens_q16), 8);
            pitch = longint'(pitch_q16) + rnd_shift(yo * longint'(sens_q16), 8);
            if (yaw >= ANG180) yaw -= 2 * ANG180;
            else if (yaw < -ANG180) yaw += 2 * ANG180;
            if (pitch > ANG89) pitch = ANG89;
            if (pitch < -ANG89) pitch = -ANG89;
            yaw_q16   = int'(yaw);
            pitch_q16 = int'(pitch);
        end
        trig(yaw_q16, cy, sy);
        trig(pitch_q16, cp, sp);
        cy14 = clip_unit(rnd_shift(cy, 16));
        sy14 = clip_unit(rnd_shift(sy, 16));
        if (!is_mouse) begin
            v = longint'(speed_q8) * dt;
            case (dir)
                DIR_FORWARD: begin move_axis(0, v, cy14);  move_axis(2, v, sy14);  end
                DIR_BACK:    begin move_axis(0, v, -cy14); move_axis(2, v, -sy14); end
                DIR_LEFT:    begin move_axis(0, v, sy14);  move_axis(2, v, -cy14); end
                DIR_RIGHT:   begin move_axis(0, v, -sy14); move_axis(2, v, cy14);  end
                DIR_DOWN:    move_axis(1, v, -16384);
                DIR_UP:      move_axis(1, v, 16384);
                default: ;
            endcase
        end
        r.pos_x   = cam_pos[0];
        r.pos_y   = cam_pos[1];
        r.pos_z   = cam_pos[2];
        r.front_x = 16'(clip_unit(rnd_shift(cy * cp, 46)));
        r.front_y = 16'(clip_unit(rnd_shift(sp, 16)));
        r.front_z = 16'(clip_unit(rnd_shift(sy * cp, 46)));
        r.right_x = 16'(-sy14);
        r.right_y = '0;
        r.right_z = 16'(cy14);
        r.up_x    = 16'(-clip_unit(rnd_shift(cy * sp, 46)));
        r.up_y    = 16'(clip_unit(rnd_shift(cp, 16)));
        r.up_z    = 16'(-clip_unit(rnd_shift(sy * sp, 46)));
        return r;
    endfunction

    function automatic int field_diff(string nm, longint want, longint got);
        if (want == got) return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want, got;
        int      bad;
        if (!rst_n) begin
            speed_q8     = 16'd1280;
            sens_q16     = 16'd13107;
            cam_pos      = '{0, 0, 0};
            yaw_q16      = YAW_RESET;
            pitch_q16    = 0;
            pending_results.delete();
            outstanding  <= 0;
            mismatches   <= 0;
            results_seen <= 0;
        end
        else begin
            bad = 0;
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_SPEED:   speed_q8 = cfg_data[15:0];
                    CFG_SENS:    sens_q16 = cfg_data[15:0];
                    CFG_START_X: cam_pos[0] = cfg_data;
                    CFG_START_Y: cam_pos[1] = cfg_data;
                    CFG_START_Z: cam_pos[2] = cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                pending_results.push_back(camera_update(in_ch.data[51:0]));
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    bad = 1;
                end
                else begin
                    want = pending_results.pop_front();
                    bad += field_diff("pos_x", want.pos_x, got.pos_x);
                    bad += field_diff("pos_y", want.pos_y, got.pos_y);
                    bad += field_diff("pos_z", want.pos_z, got.pos_z);
                    bad += field_diff("front_x", want.front_x, got.front_x);
                    bad += field_diff("front_y", want.front_y, got.front_y);
                    bad += field_diff("front_z", want.front_z, got.front_z);
                    bad += field_diff("right_x", want.right_x, got.right_x);
                    bad += field_diff("right_y", want.right_y, got.right_y);
                    bad += field_diff("right_z", want.right_z, got.right_z);
                    bad += field_diff("up_x", want.up_x, got.up_x);
                    bad += field_diff("up_y", want.up_y, got.up_y);
                    bad += field_diff("up_z", want.up_z, got.up_z);
                end
            end
            outstanding <= pending_results.size();
            mismatches  <= mismatches + bad;
        end
    end
endmodule

// ===== tb/fly_camera_orientation_update_unit_test.sv =====
// Testbench top for the camera orientation update unit: clock, reset, stimulus,
// flow control and verdict. Depends on fco_pkg, fco_if, the unit and the checker module.
`timescale 1ns / 1ps
module fly_camera_orientation_update_unit_test;
    import fco_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;   // no register behind this index
    localparam logic [2:0] DIR_NONE   = 3'd6;
    localparam int DRAIN_CYCLES = 400;          // longer than one item's latency
    localparam int STALL_LIMIT  = 40000;        // cycles with no beat on any channel
    localparam int HOLD_CYCLES  = 700;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          outstanding, mismatches, results_seen;
    int          send_idle_pct, recv_stall_pct;
    int          hold_token, hold_seen, hold_left;
    int          quiet_cycles;
    int          beats_sent;

    fco_if #(.W(52))             in_ch ();
    fco_if #(.W($bits(result_t))) out_ch ();

    fly_camera_orientation_update_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    fly_camera_orientation_update_unit_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .outstanding  (outstanding),
        .mismatches   (mismatches),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: random stalls at the phase's rate; a hold request from the
    // stimulus keeps ready low for a long stretch so the unit backs up.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_token != hold_seen) begin
            out_ch.ready <= 1'b0;
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
        end
        else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: only counts cycles in which no beat moves anywhere.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // One input beat; idle gaps come before it, the beat stays up until taken.
    task automatic send_beat(input logic kind, input logic [2:0] dir,
                             input logic [15:0] dt, input logic [15:0] xo,
                             input logic [15:0] yo);
        int gap;
        gap = 0;
        while (gap < 50 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= 52'($urandom) << 20 ^ 52'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {kind, dir, dt, xo, yo};
        do
            @(posedge clk);
        while (!in_ch.ready);
        beats_sent++;
    endtask

    task automatic key_move(input logic [2:0] dir, input logic [15:0] dt);
        send_beat(1'b0, dir, dt, 16'($urandom), 16'($urandom));
    endtask

    task automatic mouse_move(input logic [15:0] xo, input logic [15:0] yo);
        send_beat(1'b1, 3'($urandom), 16'($urandom), xo, yo);
    endtask

    // Wait until every result is back, then let the pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly small motions and time steps, now and then the field extremes.
    task automatic random_beat();
        logic [15:0] dt, xo, yo;
        case ($urandom_range(9))
            0:       dt = 16'hffff;
            1:       dt = 16'h0000;
            2, 3:    dt = 16'($urandom);
            default: dt = 16'($urandom_range(4000));
        endcase
        case ($urandom_range(9))
            0:       begin xo = 16'h8000; yo = 16'h7fff; end
            1, 2:    begin xo = 16'($urandom); yo = 16'($urandom); end
            default: begin
                xo = 16'(int'($urandom_range(8000)) - 4000);
                yo = 16'(int'($urandom_range(8000)) - 4000);
            end
        endcase
        if ($urandom_range(1))
            send_beat(1'b0, 3'($urandom_range(7)), dt, 16'($urandom), 16'($urandom));
        else
            send_beat(1'b1, 3'($urandom), 16'($urandom), xo, yo);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_SPEED;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_token     = 0;
        hold_seen      = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        beats_sent     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every direction, dt extremes and mouse extremes.
        key_move(DIR_FORWARD, 16'hffff);
        key_move(DIR_BACK, 16'h0000);
        key_move(DIR_LEFT, 16'h8000);
        key_move(DIR_RIGHT, 16'h1234);
        key_move(DIR_DOWN, 16'hffff);
        key_move(DIR_UP, 16'h0001);
        key_move(DIR_NONE, 16'hffff);
        key_move(3'd7, 16'hffff);
        mouse_move(16'h7fff, 16'h7fff);     // largest positive step on yaw and pitch
        mouse_move(16'h8000, 16'h8000);     // largest negative step on yaw and pitch
        mouse_move(16'h8000, 16'h0000);
        mouse_move(16'h7fff, 16'h0000);
        mouse_move(16'h0000, 16'h0000);
        key_move(DIR_FORWARD, 16'h4000);
        key_move(DIR_RIGHT, 16'h4000);
        drain();
        // saturation of every position component: x and y upward, z downward
        cfg_write(CFG_SPEED, 32'h0000ffff);
        cfg_write(CFG_START_X, 32'h7ffff000);
        cfg_write(CFG_START_Y, 32'h7ffff000);
        cfg_write(CFG_START_Z, 32'h80001000);
        cfg_write(CFG_UNUSED, 32'hffffffff);
        key_move(DIR_UP, 16'hffff);
        key_move(DIR_FORWARD, 16'hffff);
        mouse_move(16'h0300, 16'h0000);     // small yaw step: front stays near -z
        key_move(DIR_FORWARD, 16'hffff);
        key_move(DIR_DOWN, 16'hffff);
        key_move(DIR_BACK, 16'hffff);
        drain();

        // Random phases, each under its own register settings and one of the flow-control modes.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_SPEED, 32'd1280);
                    cfg_write(CFG_SENS, 32'd13107);
                    cfg_write(CFG_START_X, 32'd0);
                    cfg_write(CFG_START_Y, 32'd0);
                    cfg_write(CFG_START_Z, 32'd0);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    cfg_write(CFG_SPEED, 32'h0000ffff);
                    cfg_write(CFG_SENS, 32'h0000ffff);
                    cfg_write(CFG_START_X, 32'h7fffffff);
                    cfg_write(CFG_START_Y, 32'h7fffffff);
                    cfg_write(CFG_START_Z, 32'h7fffffff);
                    send_idle_pct = 72; recv_stall_pct = 0;
                end
                2: begin
                    cfg_write(CFG_SPEED, 32'd0);
                    cfg_write(CFG_SENS, 32'd0);
                    cfg_write(CFG_START_X, 32'h80000000);
                    cfg_write(CFG_START_Y, 32'h80000000);
                    cfg_write(CFG_START_Z, 32'h80000000);
                    send_idle_pct = 0;  recv_stall_pct = 72;
                end
                3: begin
                    cfg_write(CFG_SPEED, $urandom);
                    cfg_write(CFG_SENS, $urandom);
                    cfg_write(CFG_START_X, $urandom);
                    cfg_write(CFG_START_Y, $urandom);
                    cfg_write(CFG_START_Z, $urandom);
                    send_idle_pct = 36; recv_stall_pct = 36;
                end
                4: begin
                    cfg_write(CFG_SPEED, $urandom_range(65535));
                    cfg_write(CFG_SENS, $urandom_range(65535));
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    hold_token++;   // long receiver hold-off while beats keep coming
                end
                default: begin
                    cfg_write(CFG_SPEED, 32'd1);
                    cfg_write(CFG_SENS, 32'd1);
                    cfg_write(CFG_START_X, 32'd0);
                    send_idle_pct = 36; recv_stall_pct = 36;
                end
            endcase
            for (int n = 0; n < 100; n++) begin
                if (ph == 5 && n == 50) begin
                    // sender pauses until every result is back
                    in_ch.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (outstanding != 0);
                end
                random_beat();
            end
            drain();
        end

        $display("Sent %0d input beats over six register settings and four flow modes;",
                 beats_sent);
        $display("checked %0d result beats, %0d field mismatches.", results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fco_pkg.sv
rtl/fco_if.sv
rtl/fco_cordic.sv
rtl/fco_serial_mul.sv
rtl/fly_camera_orientation_update_unit.sv
tb/fly_camera_orientation_update_unit_checker.sv
tb/fly_camera_orientation_update_unit_test.sv
